// ----- sv/lennard_jones_pair_force_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Lennard-Jones pair force unit assertion macros
// Shared concurrent assertion wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef LENNARD_JONES_PAIR_FORCE_UNIT_MACROS_SVH
`define LENNARD_JONES_PAIR_FORCE_UNIT_MACROS_SVH

// clocked assertion, disabled while reset is held
`define LJPF_ASSERT_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ljpf assertion failed");

// same, on the unit clock and reset
`define LJPF_ASSERT(name, prop) `LJPF_ASSERT_CLK(name, i_clk, i_rst_n, prop)

`endif

// ----- sv/ljpf_pkg.sv -----
// ----------------------------------------------------------------------------
// Lennard-Jones pair force package
// Item types, register indexes and fixed constants.
// ----------------------------------------------------------------------------
package ljpf_pkg;

    localparam int COORD_W   = 32;
    localparam int COEF_W    = 48;
    localparam int FORCE_W   = 48;
    localparam int DIST_W    = 32;
    localparam int QUOT_W    = 50;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_NEAR_CUTOFF_SQ = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_CUTOFF_SQ  = 1'b1;

    localparam logic [DIST_W-1:0] NEAR_CUTOFF_SQ_RST = 32'd65536;
    localparam logic [DIST_W-1:0] FAR_CUTOFF_SQ_RST  = 32'd6553600;

    localparam logic [QUOT_W-1:0] QUOT_POS_MAX = 50'h0_7FFF_FFFF_FFFF;
    localparam logic [QUOT_W-1:0] QUOT_NEG_MAG = 50'h0_8000_0000_0000;

    localparam logic signed [FORCE_W-1:0] FORCE_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [FORCE_W-1:0] FORCE_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
        logic [COEF_W-1:0]         c6_coefficient;
        logic [COEF_W-1:0]         c12_coefficient;
    } t_in_item;

    typedef struct packed {
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        logic signed [FORCE_W-1:0] force_z;
        logic                      saturated;
    } t_out_item;

endpackage

// ----- sv/ljpf_dly.sv -----
// ----------------------------------------------------------------------------
// Lennard-Jones pair force delay line
// Stallable payload shift register that keeps side data aligned with stages.
// ----------------------------------------------------------------------------
module ljpf_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_q [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_q[k] <= r_q[k-1];
            end
        end
    end

    assign o_q = r_q[N-1];

endmodule

// ----- sv/ljpf_mul.sv -----
// ----------------------------------------------------------------------------
// Lennard-Jones pair force multiplier
// 32 bit by BW bit product in two stages: 32x32 limb products, then one add.
// ----------------------------------------------------------------------------
module ljpf_mul #(
    parameter int BW = 32
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [31:0]     i_a,
    input  logic [BW-1:0]   i_b,
    output logic [BW+31:0]  o_p
);

    localparam int NL  = (BW + 31) / 32;
    localparam int BXW = 32 * NL;
    localparam int PW  = BXW + 32;

    logic [BXW-1:0] w_bx;
    logic [63:0]    r_pp [NL];
    logic [PW-1:0]  w_ev;
    logic [PW-1:0]  w_od;
    logic [PW-1:0]  r_p;

    assign w_bx = BXW'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < NL; j++) begin
                r_pp[j] <= 64'(i_a) * 64'(w_bx[32*j +: 32]);
            end
            r_p <= w_ev + w_od;
        end
    end

    // even and odd limb products do not overlap among themselves
    always_comb begin
        w_ev = '0;
        w_od = '0;
        for (int j = 0; j < NL; j++) begin
            if (j[0] == 1'b0) begin
                w_ev[32*j +: 64] = r_pp[j];
            end else begin
                w_od[32*j +: 64] = r_pp[j];
            end
        end
    end

    assign o_p = r_p[BW+31:0];

endmodule

// ----- sv/ljpf_div.sv -----
// ----------------------------------------------------------------------------
// Lennard-Jones pair force divider
// Three-lane restoring divider, one quotient bit per stage, shared divisor.
// ----------------------------------------------------------------------------
module ljpf_div #(
    parameter int MW = 227,
    parameter int PW = 224,
    parameter int CW = 273
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [MW-1:0]               i_m [3],
    input  logic [PW-1:0]               i_p,
    output logic [ljpf_pkg::QUOT_W-1:0] o_q [3]
);

    localparam int QW = ljpf_pkg::QUOT_W;

    logic [CW-1:0] r_rem [3][QW];
    logic [QW-1:0] r_q   [3][QW];
    logic [PW-1:0] r_div [QW];
    logic [CW-1:0] n_rem [3][QW];
    logic [QW-1:0] n_q   [3][QW];

    always_comb begin
        logic [CW-1:0] lim;
        logic [CW:0]   dif;
        lim = '0;
        dif = '0;
        for (int l = 0; l < 3; l++) begin
            // top bit: quotient at or above the cap ends the division
            n_rem[l][0] = CW'(i_m[l]);
            n_q[l][0]   = (CW'(i_m[l]) >= (CW'(i_p) << (QW - 1))) ?
                          (QW'(1) << (QW - 1)) : '0;
            for (int s = 1; s < QW; s++) begin
                lim = CW'(r_div[s-1]) << (QW - 1 - s);
                dif = {1'b0, r_rem[l][s-1]} - {1'b0, lim};
                n_rem[l][s] = r_rem[l][s-1];
                n_q[l][s]   = r_q[l][s-1];
                if (!r_q[l][s-1][QW-1] && !dif[CW]) begin
                    n_rem[l][s]          = dif[CW-1:0];
                    n_q[l][s][QW-1-s]    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem    <= n_rem;
            r_q      <= n_q;
            r_div[0] <= i_p;
            for (int s = 1; s < QW; s++) begin
                r_div[s] <= r_div[s-1];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            o_q[l] = r_q[l][QW-1];
        end
    end

endmodule

// ----- sv/lennard_jones_pair_force_unit.sv -----
// Throughput: one item per cycle; every stage of the power chain, the limb
// multipliers and the 50-stage restoring divider takes a new item each cycle,
// except while the queue is full and the output is not ready, when all stall.
// A two-entry output queue keeps the input open while one result waits.
// Reset: synchronous, active low; clears the valid pipeline and the queue,
// and loads the default near and far cutoffs.
// ----------------------------------------------------------------------------
// Lennard-Jones pair force unit
// Fixed-point 12-6 pair force with near clamp and far cutoff, fully pipelined.
// ----------------------------------------------------------------------------
module lennard_jones_pair_force_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ljpf_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ljpf_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ljpf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ljpf_pkg::DIST_W-1:0]         i_cfg_data
);

    localparam int DW_  = ljpf_pkg::DIST_W;
    localparam int QW   = ljpf_pkg::QUOT_W;
    localparam int FW   = ljpf_pkg::FORCE_W;
    localparam int A0W  = ljpf_pkg::COEF_W + 3;
    localparam int B0W  = ljpf_pkg::COEF_W + 4;
    localparam int AW   = A0W + 3 * DW_;
    localparam int ASW  = AW + 3 * FRAC_BITS;
    localparam int BSW  = B0W + 6 * FRAC_BITS;
    localparam int TW   = (ASW > BSW) ? ASW : BSW;
    localparam int SW   = TW + 1;
    localparam int MW   = TW + DW_;
    localparam int PW   = 7 * DW_;
    localparam int CW   = (MW > PW + QW - 1) ? MW : PW + QW - 1;
    localparam int LAT  = 71;
    localparam logic [1:0] FIFO_FULL = 2'd2;

    logic [DW_-1:0] r_near;
    logic [DW_-1:0] r_far;
    logic           w_en;
    logic [LAT-1:0] r_vld;

    // ---------------- configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= ljpf_pkg::NEAR_CUTOFF_SQ_RST;
            r_far  <= ljpf_pkg::FAR_CUTOFF_SQ_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ljpf_pkg::REG_NEAR_CUTOFF_SQ: r_near <= i_cfg_data;
                ljpf_pkg::REG_FAR_CUTOFF_SQ:  r_far  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- distance front end
    logic signed [32:0] r1_dd [3];
    logic [A0W-1:0]     r1_c6;
    logic [B0W-1:0]     r1_c12;
    logic [DW_-1:0]     r2_mag [3];
    logic [63:0]        r3_sq [3];
    logic [65:0]        r4_s;
    logic [DW_-1:0]     r5_d;
    logic               r5_far;
    logic [63:0]        w_sh;
    logic [DW_-1:0]     w_d;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dd[0] <= {i_in_data.second_x[31], i_in_data.second_x}
                      - {i_in_data.first_x[31], i_in_data.first_x};
            r1_dd[1] <= {i_in_data.second_y[31], i_in_data.second_y}
                      - {i_in_data.first_y[31], i_in_data.first_y};
            r1_dd[2] <= {i_in_data.second_z[31], i_in_data.second_z}
                      - {i_in_data.first_z[31], i_in_data.first_z};
            r1_c6    <= (A0W'(i_in_data.c6_coefficient) << 2)
                      + (A0W'(i_in_data.c6_coefficient) << 1);
            r1_c12   <= (B0W'(i_in_data.c12_coefficient) << 3)
                      + (B0W'(i_in_data.c12_coefficient) << 2);
            for (int k = 0; k < 3; k++) begin
                r2_mag[k] <= r1_dd[k][32] ? 32'(-r1_dd[k]) : r1_dd[k][31:0];
                r3_sq[k]  <= 64'(r2_mag[k]) * 64'(r2_mag[k]);
            end
            r4_s   <= 66'(r3_sq[0]) + 66'(r3_sq[1]) + 66'(r3_sq[2]);
            r5_d   <= w_d;
            r5_far <= (|r4_s[65:64]) || (w_sh > 64'(r_far));
        end
    end

    always_comb begin
        w_sh = r4_s[63:0] >> FRAC_BITS;
        w_d  = w_sh[DW_-1:0];
        if (w_sh < 64'(r_near)) begin
            w_d = r_near;
        end
        if (w_d == '0) begin
            w_d = DW_'(1);
        end
    end

    // ---------------- powers of d and the attractive term
    logic [PW-1:0]  w_pw [7];
    logic [DW_-1:0] w_dd_d [6];
    logic [AW-1:0]  w_a [4];
    logic [A0W-1:0] w_c6_d;

    assign w_pw[0]   = PW'(r5_d);
    assign w_dd_d[0] = r5_d;
    assign w_a[0]    = AW'(w_c6_d);

    ljpf_dly #(.W(A0W), .N(4)) u_c6_dly (
        .i_clk(i_clk), .i_en(w_en), .i_d(r1_c6), .o_q(w_c6_d)
    );

    for (genvar g = 1; g < 7; g++) begin : g_pow
        logic [DW_*(g+1)-1:0] w_p;
        ljpf_mul #(.BW(DW_ * g)) u_mul (
            .i_clk(i_clk), .i_en(w_en), .i_a(w_dd_d[g-1]),
            .i_b(w_pw[g-1][DW_*g-1:0]), .o_p(w_p)
        );
        assign w_pw[g] = PW'(w_p);
        if (g < 6) begin : g_dly
            ljpf_dly #(.W(DW_), .N(2)) u_dly (
                .i_clk(i_clk), .i_en(w_en), .i_d(w_dd_d[g-1]), .o_q(w_dd_d[g])
            );
        end
    end

    for (genvar j = 1; j < 4; j++) begin : g_att
        logic [A0W+DW_*j-1:0] w_p;
        ljpf_mul #(.BW(A0W + DW_ * (j - 1))) u_mul (
            .i_clk(i_clk), .i_en(w_en), .i_a(w_dd_d[j-1]),
            .i_b(w_a[j-1][A0W+DW_*(j-1)-1:0]), .o_p(w_p)
        );
        assign w_a[j] = AW'(w_p);
    end

    logic [AW-1:0]  w_a3_d;
    logic [B0W-1:0] w_c12_d;
    logic [PW-1:0]  w_p7_d;

    ljpf_dly #(.W(AW), .N(6)) u_a_dly (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_a[3]), .o_q(w_a3_d)
    );
    ljpf_dly #(.W(B0W), .N(16)) u_c12_dly (
        .i_clk(i_clk), .i_en(w_en), .i_d(r1_c12), .o_q(w_c12_d)
    );
    ljpf_dly #(.W(PW), .N(4)) u_p7_dly (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_pw[6]), .o_q(w_p7_d)
    );

    // ---------------- T = 6*C6*D^3 - 12*C12, scaled
    logic [SW-1:0] r18_diff;
    logic [TW-1:0] r19_t;
    logic          r19_tneg;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r18_diff <= (SW'(w_a3_d) << (3 * FRAC_BITS))
                      - (SW'(w_c12_d) << (6 * FRAC_BITS));
            r19_tneg <= r18_diff[TW];
            r19_t    <= r18_diff[TW] ? TW'(-r18_diff) : r18_diff[TW-1:0];
        end
    end

    // ---------------- side data to the divider input and output
    logic [3*DW_-1:0] w_mag_d;
    logic [2:0]       w_sgn_d;
    logic             w_far_d;
    logic [3:0]       w_flags;

    ljpf_dly #(.W(3 * DW_), .N(17)) u_mag_dly (
        .i_clk(i_clk), .i_en(w_en), .i_d({r2_mag[2], r2_mag[1], r2_mag[0]}),
        .o_q(w_mag_d)
    );
    ljpf_dly #(.W(3), .N(18)) u_sgn_dly (
        .i_clk(i_clk), .i_en(w_en), .i_d({r1_dd[2][32], r1_dd[1][32], r1_dd[0][32]}),
        .o_q(w_sgn_d)
    );
    ljpf_dly #(.W(1), .N(14)) u_far_dly (
        .i_clk(i_clk), .i_en(w_en), .i_d(r5_far), .o_q(w_far_d)
    );
    ljpf_dly #(.W(4), .N(52)) u_flag_dly (
        .i_clk(i_clk), .i_en(w_en), .i_d({w_far_d, w_sgn_d ^ {3{r19_tneg}}}),
        .o_q(w_flags)
    );

    // ---------------- numerators and division
    logic [MW-1:0] w_m [3];
    logic [QW-1:0] w_q [3];

    for (genvar k = 0; k < 3; k++) begin : g_num
        ljpf_mul #(.BW(TW)) u_mul (
            .i_clk(i_clk), .i_en(w_en), .i_a(w_mag_d[DW_*k +: DW_]),
            .i_b(r19_t), .o_p(w_m[k])
        );
    end

    ljpf_div #(.MW(MW), .PW(PW), .CW(CW)) u_div (
        .i_clk(i_clk), .i_en(w_en), .i_m(w_m), .i_p(w_p7_d), .o_q(w_q)
    );

    // ---------------- sign, saturation, far zero
    ljpf_pkg::t_out_item w_res;

    always_comb begin
        logic [QW-1:0] q_clip;
        logic [FW-1:0] mag48;
        logic [FW-1:0] comp [3];
        logic          sat;
        sat    = 1'b0;
        q_clip = '0;
        mag48  = '0;
        for (int k = 0; k < 3; k++) begin
            q_clip = w_q[k];
            if (!w_flags[k] && w_q[k] > ljpf_pkg::QUOT_POS_MAX) begin
                q_clip = ljpf_pkg::QUOT_POS_MAX;
                sat    = 1'b1;
            end
            if (w_flags[k] && w_q[k] > ljpf_pkg::QUOT_NEG_MAG) begin
                q_clip = ljpf_pkg::QUOT_NEG_MAG;
                sat    = 1'b1;
            end
            mag48   = q_clip[FW-1:0];
            comp[k] = w_flags[k] ? (FW'(0) - mag48) : mag48;
        end
        if (w_flags[3]) begin
            w_res = '0;
        end else begin
            w_res.force_x   = comp[0];
            w_res.force_y   = comp[1];
            w_res.force_z   = comp[2];
            w_res.saturated = sat;
        end
    end

    // ---------------- valid pipeline and output queue
    ljpf_pkg::t_out_item r_fifo [2];
    logic                r_wptr;
    logic                r_rptr;
    logic [1:0]          r_cnt;
    logic                w_push;
    logic                w_pop;

    assign w_en        = (r_cnt != FIFO_FULL) || i_out_ready;
    assign o_in_ready  = w_en;
    assign w_push      = w_en && r_vld[LAT-1];
    assign w_pop       = o_out_valid && i_out_ready;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_fifo[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[LAT-2:0], i_in_valid};
            end
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= 2'(r_cnt + {1'b0, w_push} - {1'b0, w_pop});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wptr] <= w_res;
        end
    end

endmodule

// ----- sv/ljpf_checker.sv -----
// ----------------------------------------------------------------------------
// Lennard-Jones pair force checker
// Port-level assertions on the output queue and saturation reporting.
// ----------------------------------------------------------------------------
`include "lennard_jones_pair_force_unit_macros.svh"

module ljpf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input ljpf_pkg::t_out_item o_out_data
);

    logic w_at_limit;

    assign w_at_limit = (o_out_data.force_x == ljpf_pkg::FORCE_MAX)
                     || (o_out_data.force_x == ljpf_pkg::FORCE_MIN)
                     || (o_out_data.force_y == ljpf_pkg::FORCE_MAX)
                     || (o_out_data.force_y == ljpf_pkg::FORCE_MIN)
                     || (o_out_data.force_z == ljpf_pkg::FORCE_MAX)
                     || (o_out_data.force_z == ljpf_pkg::FORCE_MIN);

    `LJPF_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid)
    `LJPF_ASSERT(a_out_stable, o_out_valid && !i_out_ready |=> $stable(o_out_data))
    `LJPF_ASSERT(a_ready_when_empty, !o_out_valid |-> o_in_ready)
    `LJPF_ASSERT(a_ready_on_take, o_out_valid && i_out_ready |-> o_in_ready)
    `LJPF_ASSERT(a_sat_at_limit, o_out_valid && o_out_data.saturated |-> w_at_limit)

endmodule

bind lennard_jones_pair_force_unit ljpf_checker u_ljpf_checker (.*);
